@@ sv/pcs_pkg.sv @@
// Package: shared types and constants for the polynomial coefficient statistics block.
`timescale 1ns / 1ps

package pcs_pkg;

    localparam int COEFF_W   = 24;   // coefficient and content width
    localparam int SUM_W     = 29;   // value at one width
    localparam int OUT_IDX_W = 5;    // degree / valuation field width
    localparam int K_W       = $clog2(COEFF_W);
    localparam int TDATA_W   = 128;  // result beat, padded to whole bytes
    localparam int TUSER_W   = 2;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Per-polynomial statistics computed by the front end
    typedef struct packed {
        logic [OUT_IDX_W-1:0] degree;
        logic [OUT_IDX_W-1:0] valuation;
        logic [COEFF_W-1:0]   value_at_zero;
        logic [SUM_W-1:0]     value_at_one;
        logic [COEFF_W-1:0]   leading_coeff;
        logic [OUT_IDX_W-1:0] max_degree_seen;
        logic [OUT_IDX_W-1:0] max_valuation_seen;
        logic                 is_zero;
        logic                 too_long;
    } pcs_stats_t;

    // One queue entry: coefficient for the gcd unit plus closing snapshot
    typedef struct packed {
        logic [COEFF_W-1:0] coeff;
        logic               use_coeff;  // coefficient is inside the degree bound
        logic               last;
        pcs_stats_t         stats;      // meaningful on the closing entry only
    } pcs_entry_t;

    // Finished result
    typedef struct packed {
        pcs_stats_t         stats;
        logic [COEFF_W-1:0] content;
    } pcs_result_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_GCD,
        BK_DONE
    } pcs_back_state_t;

endpackage

@@ sv/pcs_fifo.sv @@
// Small register queue between the front end and the gcd back end.
`timescale 1ns / 1ps

module pcs_fifo
    import pcs_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pcs_entry_t push_data,
    output logic       full,
    input  logic       pop,
    output logic       empty,
    output pcs_entry_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pcs_entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/pcs_front.sv @@
// Front end: accepts coefficient beats and keeps the cheap per-polynomial statistics.
`timescale 1ns / 1ps

module pcs_front
    import pcs_pkg::*;
#(
    parameter int MAX_DEGREE = 31
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [COEFF_W-1:0] s_tdata,   // [23:0] coefficient
    input  logic               s_tlast,   // last (leading) coefficient
    output logic               q_push,
    input  logic               q_full,
    output pcs_entry_t         q_entry
);

    localparam int IDX_W = $clog2(MAX_DEGREE + 1);
    localparam int CNT_W = $clog2(MAX_DEGREE + 2);

    logic [CNT_W-1:0]   count_reg,      count_next;
    logic [IDX_W-1:0]   first_nz_reg,   first_nz_next;
    logic               seen_nz_reg,    seen_nz_next;
    logic [COEFF_W-1:0] const_reg,      const_next;
    logic [SUM_W-1:0]   sum_reg,        sum_next;
    logic [COEFF_W-1:0] lead_reg,       lead_next;
    logic               ovl_reg,        ovl_next;
    logic [IDX_W-1:0]   max_deg_reg,    max_deg_next;
    logic [IDX_W-1:0]   max_val_reg,    max_val_next;

    logic               accept;
    logic               in_bound;
    logic [SUM_W:0]     sum_wide;
    logic [CNT_W-1:0]   cnt_upd;
    logic [IDX_W-1:0]   fnz_upd;
    logic               seen_upd;
    logic [COEFF_W-1:0] const_upd;
    logic [SUM_W-1:0]   sum_upd;
    logic [COEFF_W-1:0] lead_upd;
    logic               ovl_upd;
    logic [IDX_W-1:0]   deg_upd;
    logic [IDX_W-1:0]   val_upd;
    logic [IDX_W-1:0]   mdeg_upd;
    logic [IDX_W-1:0]   mval_upd;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign q_push   = accept;
    assign in_bound = (count_reg <= CNT_W'(MAX_DEGREE));
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(s_tdata);

    // Statistics after this beat
    always_comb
    begin
        cnt_upd   = count_reg;
        fnz_upd   = first_nz_reg;
        seen_upd  = seen_nz_reg;
        const_upd = const_reg;
        sum_upd   = sum_reg;
        lead_upd  = lead_reg;
        ovl_upd   = ovl_reg;
        if (in_bound)
        begin
            if (count_reg == '0)
            begin
                const_upd = s_tdata;
            end
            if (s_tdata != '0 && !seen_nz_reg)
            begin
                seen_upd = 1'b1;
                fnz_upd  = count_reg[IDX_W-1:0];
            end
            sum_upd  = (sum_wide > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
            lead_upd = s_tdata;
            cnt_upd  = count_reg + 1'b1;
        end
        else
        begin
            ovl_upd = 1'b1;
        end
        deg_upd  = IDX_W'(cnt_upd - 1'b1);
        val_upd  = seen_upd ? fnz_upd : '0;
        mdeg_upd = max_deg_reg;
        mval_upd = max_val_reg;
        if (seen_upd && !ovl_upd)
        begin
            if (deg_upd > max_deg_reg)
            begin
                mdeg_upd = deg_upd;
            end
            if (val_upd > max_val_reg)
            begin
                mval_upd = val_upd;
            end
        end
    end

    // Queue entry: snapshot is taken on the closing beat
    always_comb
    begin
        q_entry.coeff                    = s_tdata;
        q_entry.use_coeff                = in_bound;
        q_entry.last                     = s_tlast;
        q_entry.stats.degree             = OUT_IDX_W'(deg_upd);
        q_entry.stats.valuation          = OUT_IDX_W'(val_upd);
        q_entry.stats.value_at_zero      = const_upd;
        q_entry.stats.value_at_one       = sum_upd;
        q_entry.stats.leading_coeff      = lead_upd;
        q_entry.stats.max_degree_seen    = OUT_IDX_W'(mdeg_upd);
        q_entry.stats.max_valuation_seen = OUT_IDX_W'(mval_upd);
        q_entry.stats.is_zero            = !seen_upd;
        q_entry.stats.too_long           = ovl_upd;
    end

    // Next state: clear per-polynomial state after the closing beat
    always_comb
    begin
        count_next    = count_reg;
        first_nz_next = first_nz_reg;
        seen_nz_next  = seen_nz_reg;
        const_next    = const_reg;
        sum_next      = sum_reg;
        lead_next     = lead_reg;
        ovl_next      = ovl_reg;
        max_deg_next  = max_deg_reg;
        max_val_next  = max_val_reg;
        if (accept)
        begin
            max_deg_next = s_tlast ? mdeg_upd : max_deg_reg;
            max_val_next = s_tlast ? mval_upd : max_val_reg;
            if (s_tlast)
            begin
                count_next    = '0;
                first_nz_next = '0;
                seen_nz_next  = 1'b0;
                const_next    = '0;
                sum_next      = '0;
                lead_next     = '0;
                ovl_next      = 1'b0;
            end
            else
            begin
                count_next    = cnt_upd;
                first_nz_next = fnz_upd;
                seen_nz_next  = seen_upd;
                const_next    = const_upd;
                sum_next      = sum_upd;
                lead_next     = lead_upd;
                ovl_next      = ovl_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            first_nz_reg <= '0;
            seen_nz_reg  <= 1'b0;
            const_reg    <= '0;
            sum_reg      <= '0;
            lead_reg     <= '0;
            ovl_reg      <= 1'b0;
            max_deg_reg  <= '0;
            max_val_reg  <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            first_nz_reg <= first_nz_next;
            seen_nz_reg  <= seen_nz_next;
            const_reg    <= const_next;
            sum_reg      <= sum_next;
            lead_reg     <= lead_next;
            ovl_reg      <= ovl_next;
            max_deg_reg  <= max_deg_next;
            max_val_reg  <= max_val_next;
        end
    end

endmodule

@@ sv/pcs_back.sv @@
// Back end: binary gcd unit folding each coefficient into the content, plus result register.
`timescale 1ns / 1ps

module pcs_back
    import pcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_pop,
    input  pcs_entry_t  q_entry,
    output logic        m_valid,
    input  logic        m_ready,
    output pcs_result_t m_result
);

    pcs_back_state_t    state_reg, state_next;
    pcs_entry_t         cur_reg,   cur_next;
    logic [COEFF_W-1:0] a_reg,     a_next;
    logic [COEFF_W-1:0] b_reg,     b_next;
    logic [K_W-1:0]     k_reg,     k_next;
    logic [COEFF_W-1:0] g_reg,     g_next;
    pcs_result_t        res_reg,   res_next;
    logic               valid_reg, valid_next;

    assign m_valid  = valid_reg;
    assign m_result = res_reg;

    // Sequencer and one binary gcd step per cycle
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        g_next     = g_reg;
        res_next   = res_reg;
        valid_next = valid_reg;
        q_pop      = 1'b0;

        if (valid_reg && m_ready)
        begin
            valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_entry;
                    if (q_entry.use_coeff)
                    begin
                        a_next     = g_reg;
                        b_next     = q_entry.coeff;
                        k_next     = '0;
                        state_next = BK_GCD;
                    end
                    else if (q_entry.last)
                    begin
                        state_next = BK_DONE;
                    end
                end
            end
            BK_GCD:
            begin
                if (a_reg == '0 || b_reg == '0)
                begin
                    // one operand gone: the other, rescaled, is the gcd
                    g_next     = (a_reg == '0) ? (b_reg << k_reg) : (a_reg << k_reg);
                    state_next = cur_reg.last ? BK_DONE : BK_IDLE;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (a_reg >= b_reg)
                begin
                    a_next = (a_reg - b_reg) >> 1;
                end
                else
                begin
                    b_next = (b_reg - a_reg) >> 1;
                end
            end
            BK_DONE:
            begin
                if (!valid_reg || m_ready)
                begin
                    res_next.stats   = cur_reg.stats;
                    res_next.content = g_reg;
                    valid_next       = 1'b1;
                    g_next           = '0;
                    state_next       = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            g_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            g_reg     <= g_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

endmodule

@@ sv/polynomial_coefficient_statistics_top.sv @@
// Top level: polynomial coefficient statistics, front end, beat queue and gcd back end.
// Flow: a closing beat is pushed into the queue, popped by the back end, run through its gcd
//   steps, finished and registered as the output result; a dropped one skips the gcd steps.
// The shared binary gcd unit sets the rate: a dropped coefficient is only popped, a zero one goes
//   straight to the finishing step, a nonzero one is reduced by one shift or subtract per cycle.
// A 4-beat queue lets the front end keep accepting while the gcd unit works.
// Reset (rst_n, async, active low) clears all statistics, the running maxima and the queue.
`timescale 1ns / 1ps

module polynomial_coefficient_statistics_top
    import pcs_pkg::*;
#(
    parameter int MAX_DEGREE = 31
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [COEFF_W-1:0] s_tdata,   // [23:0] coefficient
    input  logic               s_tlast,   // last
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // degree, valuation, value_at_zero, value_at_one,
                                          // leading_coeff, content, max_degree_seen,
                                          // max_valuation_seen, zero pad
    output logic [TUSER_W-1:0] m_tuser    // is_zero, too_long
);

    localparam int QUEUE_DEPTH = 4;
    localparam int PAD_W = TDATA_W - (4 * OUT_IDX_W + 3 * COEFF_W + SUM_W);

    logic        q_push;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    pcs_entry_t  q_in;
    pcs_entry_t  q_out;
    pcs_result_t result;

    pcs_front #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_entry  (q_in)
    );

    pcs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_out)
    );

    pcs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (!q_empty),
        .q_pop    (q_pop),
        .q_entry  (q_out),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    // Result beat packing, first field in the low bits
    assign m_tdata = {
        {PAD_W{1'b0}},
        result.stats.max_valuation_seen,
        result.stats.max_degree_seen,
        result.content,
        result.stats.leading_coeff,
        result.stats.value_at_one,
        result.stats.value_at_zero,
        result.stats.valuation,
        result.stats.degree
    };
    assign m_tuser = {result.stats.too_long, result.stats.is_zero};

endmodule
